// ===== rtl/int32_to_decimal_ascii_defines.svh =====
// Assertion macros shared by the conversion block.
`ifndef INT32_TO_DECIMAL_ASCII_DEFINES_SVH
`define INT32_TO_DECIMAL_ASCII_DEFINES_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define I2DA_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("i2da assertion failed");
// Condition that must never be seen outside reset.
`define I2DA_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("i2da forbidden condition seen");
`else
`define I2DA_ASSERT(label, clk, rstn, prop)
`define I2DA_NEVER(label, clk, rstn, cond)
`endif

`endif

// ===== rtl/i2da_pkg.sv =====
package i2da_pkg;

    // Input width and the number of decimal digits it can need
    localparam int unsigned ValueWidth = 32;
    localparam int unsigned NumDigits  = 10;
    localparam int unsigned CntWidth   = $clog2(ValueWidth);
    localparam int unsigned RemWidth   = $clog2(NumDigits + 1);

    // ASCII codes
    localparam logic [7:0] CharMinus = 8'd45;
    localparam logic [3:0] DigitHigh = 4'h3;   // '0'..'9' are 0x30..0x39

    typedef logic [3:0] bcd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    // Control broadcast to every digit cell
    typedef struct packed {
        logic clear;   // load zero
        logic dbl;     // add-3 correction, then shift one bit in
        logic dshift;  // move one whole digit toward the top cell
    } cell_ctrl_t;

endpackage

// ===== rtl/int32_to_decimal_ascii.sv =====
// Signed 32-bit integer to decimal ASCII text.
// Input channel s_*: one signed value per item on s_value (valid/ready).
// Result channel m_*: one ASCII character per item on m_character, most
// significant first, with m_last high on the final character. Negative
// values start with '-'; no leading zeros; zero gives "0".
// The magnitude is converted by a row of ten BCD digit cells, one input bit
// per cycle, then the row shifts digit by digit toward the top cell, which
// feeds the output register; leading zeros are dropped there one per cycle.
// One item is worked at a time: s_ready is high only while idle.
// A stall on m_ready holds the character in the output register; digits
// wait in the row until it frees, while leading zeros are still dropped and
// the next item may be converted meanwhile; nothing is lost. A synchronous
// low aresetn returns to idle with no character pending.
`include "int32_to_decimal_ascii_defines.svh"

module int32_to_decimal_ascii
    import i2da_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic signed [ValueWidth-1:0] s_value,
    input  logic                         s_valid,
    output logic                         s_ready,
    output logic [7:0]                   m_character,
    output logic                         m_last,
    output logic                         m_valid,
    input  logic                         m_ready
);

    state_t state_reg, state_next;

    logic [ValueWidth-1:0] mag_reg;
    logic [CntWidth-1:0]   cnt_reg;
    logic [RemWidth-1:0]   rem_reg;
    logic                  sign_pend_reg;
    logic                  started_reg;
    logic                  m_valid_reg, m_valid_next;
    logic [7:0]            m_character_reg;
    logic                  m_last_reg;

    cell_ctrl_t ctrl;
    logic       accept;
    logic       out_free;
    logic       skip;
    logic       emit_sign;
    logic       emit_digit;
    bcd_t       top_digit;

    logic [NumDigits:0] carry;
    bcd_t               digit [NumDigits];

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Row of digit cells: bits enter at the bottom, digits leave at the top
    assign carry[0] = mag_reg[ValueWidth-1];
    for (genvar i = 0; i < NumDigits; i++) begin : g_cell
        bcd_t din;
        if (i == 0) begin : g_first
            assign din = '0;
        end else begin : g_rest
            assign din = digit[i-1];
        end
        i2da_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .bit_in    (carry[i]),
            .digit_in  (din),
            .carry_out (carry[i+1]),
            .digit_out (digit[i])
        );
    end

    assign top_digit = digit[NumDigits-1];
    assign skip = !sign_pend_reg && !started_reg && (top_digit == '0)
                  && (rem_reg != RemWidth'(1));

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_CONV;
            end
            ST_CONV: begin
                if (cnt_reg == CntWidth'(ValueWidth - 1)) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (emit_digit && rem_reg == RemWidth'(1)) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_ready     = 1'b0;
        ctrl        = '0;
        emit_sign   = 1'b0;
        emit_digit  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                ctrl.clear = accept;
            end
            ST_CONV: begin
                ctrl.dbl = 1'b1;
            end
            ST_EMIT: begin
                emit_sign   = sign_pend_reg && out_free;
                emit_digit  = !sign_pend_reg && !skip && out_free;
                ctrl.dshift = skip || emit_digit;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Output register valid
    always_comb begin
        if (emit_sign || emit_digit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            sign_pend_reg <= 1'b0;
            started_reg   <= 1'b0;
            cnt_reg       <= '0;
            rem_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (accept) begin
                sign_pend_reg <= s_value[ValueWidth-1];
                started_reg   <= 1'b0;
                cnt_reg       <= '0;
                rem_reg       <= RemWidth'(NumDigits);
            end else begin
                if (ctrl.dbl) cnt_reg <= cnt_reg + CntWidth'(1);
                if (emit_sign) sign_pend_reg <= 1'b0;
                if (emit_digit) started_reg <= 1'b1;
                if (ctrl.dshift) rem_reg <= rem_reg - RemWidth'(1);
            end
        end
    end

    // Magnitude shifter and output payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            mag_reg <= s_value[ValueWidth-1] ? (~s_value + ValueWidth'(1)) : s_value;
        end else if (ctrl.dbl) begin
            mag_reg <= {mag_reg[ValueWidth-2:0], 1'b0};
        end
        if (emit_sign) begin
            m_character_reg <= CharMinus;
            m_last_reg      <= 1'b0;
        end else if (emit_digit) begin
            m_character_reg <= {DigitHigh, top_digit};
            m_last_reg      <= (rem_reg == RemWidth'(1));
        end
    end

    assign m_character = m_character_reg;
    assign m_last      = m_last_reg;
    assign m_valid     = m_valid_reg;

    // Checks
    `I2DA_ASSERT(a_accept_starts_conv, aclk, aresetn, accept |=> (state_reg == ST_CONV))
    `I2DA_NEVER(a_sign_not_last, aclk, aresetn, m_valid && (m_character == CharMinus) && m_last)
    `I2DA_NEVER(a_top_digit_bcd, aclk, aresetn, (state_reg == ST_EMIT) && (top_digit > 4'd9))
    `I2DA_NEVER(a_rem_nonzero, aclk, aresetn, (state_reg == ST_EMIT) && (rem_reg == '0))

endmodule

// ===== rtl/i2da_cell.sv =====
module i2da_cell
    import i2da_pkg::*;
(
    input  logic       aclk,
    input  cell_ctrl_t ctrl,
    input  logic       bit_in,
    input  bcd_t       digit_in,
    output logic       carry_out,
    output bcd_t       digit_out
);

    bcd_t digit_reg;
    bcd_t adj;

    // Add 3 to digits of 5 and up so the shift carries into the next decade
    assign adj       = (digit_reg >= 4'd5) ? bcd_t'(digit_reg + 4'd3) : digit_reg;
    assign carry_out = adj[3];
    assign digit_out = digit_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            digit_reg <= '0;
        end else if (ctrl.dbl) begin
            digit_reg <= {adj[2:0], bit_in};
        end else if (ctrl.dshift) begin
            digit_reg <= digit_in;
        end
    end

endmodule
